### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// Clocked assertion that also holds through reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("checker assertion failed during or after reset");

`endif

### src/hftd_pkg.sv
// Types and constants shared by the Huffman tree bit decoder modules.
package hftd_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int IDX_W      = 10;
    localparam int SYM_W      = 16;
    localparam int CNT_W      = 31;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic CMD_NODE_WR = 1'b0;
    localparam logic CMD_BIT     = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        node_index;
        logic                    node_is_leaf;
        logic [IDX_W-1:0]        left_child;
        logic [IDX_W-1:0]        right_child;
        logic signed [SYM_W-1:0] leaf_symbol;
        logic                    code_bit;
    } t_in_item;

    typedef struct packed {
        logic signed [SYM_W-1:0] symbol;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic                    leaf;
        logic [IDX_W-1:0]        left;
        logic [IDX_W-1:0]        right;
        logic signed [SYM_W-1:0] sym;
    } t_node;

    typedef enum logic {
        OP_NODE_WR,
        OP_BIT
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic [IDX_W-1:0] idx;
        t_node            node;
        logic             code_bit;
    } t_op;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_back_state;

endpackage

### src/hftd_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module hftd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hftd_pkg::t_in_item  i_data,
    output hftd_pkg::t_qhead    o_head,
    input  logic                i_pop
);

    hftd_pkg::t_op                    r_q [hftd_pkg::QDEPTH];
    logic [hftd_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [hftd_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [hftd_pkg::QCNT_W-1:0]      r_count, n_count;
    hftd_pkg::t_op                    op_in;
    logic                             push;
    logic                             pop;

    // classify the incoming request
    always_comb begin
        op_in.kind      = (i_data.cmd == hftd_pkg::CMD_BIT) ? hftd_pkg::OP_BIT
                                                            : hftd_pkg::OP_NODE_WR;
        op_in.idx       = i_data.node_index;
        op_in.node.leaf = i_data.node_is_leaf;
        op_in.node.left = i_data.left_child;
        op_in.node.right = i_data.right_child;
        op_in.node.sym  = i_data.leaf_symbol;
        op_in.code_bit  = i_data.code_bit;
    end

    assign o_ready      = (r_count != hftd_pkg::QCNT_W'(hftd_pkg::QDEPTH));
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

endmodule

### src/hftd_back.sv
// Back end: node memory, tree walk, symbol count and output register.
module hftd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hftd_pkg::t_qhead             i_head,
    output logic                         o_pop,
    input  logic                         i_cfg_we,
    input  logic [hftd_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hftd_pkg::t_out_item          o_data
);

    hftd_pkg::t_node                  mem [hftd_pkg::NODE_COUNT];

    hftd_pkg::t_back_state            r_state, n_state;
    hftd_pkg::t_node                  r_cur, n_cur;
    hftd_pkg::t_node                  r_root, n_root;
    hftd_pkg::t_node                  r_rd;
    logic [hftd_pkg::CNT_W-1:0]       r_left, n_left;
    logic                             r_finished, n_finished;
    logic                             r_out_valid, n_out_valid;
    hftd_pkg::t_out_item              r_out, n_out;

    logic                             slot_free;
    logic                             emit;
    logic signed [hftd_pkg::SYM_W-1:0] emit_sym;
    logic                             mem_we;
    logic                             rd_en;
    logic [hftd_pkg::IDX_W-1:0]       next_child;
    logic                             child_out;
    logic                             idx_ok;

    assign slot_free  = !r_out_valid || i_ready;
    assign next_child = i_head.op.code_bit ? r_cur.right : r_cur.left;
    assign child_out  = (int'(next_child) >= hftd_pkg::NODE_COUNT);
    assign idx_ok     = (int'(i_head.op.idx) < hftd_pkg::NODE_COUNT);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_root   = r_root;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        emit     = 1'b0;
        emit_sym = r_cur.sym;
        case (r_state)
            hftd_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.op.kind)
                        hftd_pkg::OP_NODE_WR: begin
                            o_pop  = 1'b1;
                            mem_we = idx_ok;
                            // any node write sends the walk back to the root
                            if (i_head.op.idx == '0) begin
                                n_root = i_head.op.node;
                                n_cur  = i_head.op.node;
                            end else begin
                                n_cur  = r_root;
                            end
                        end
                        hftd_pkg::OP_BIT: begin
                            if (r_finished) begin
                                o_pop = 1'b1;
                            end else if (r_cur.leaf) begin
                                // root is a leaf: emit it on every bit
                                if (slot_free) begin
                                    o_pop    = 1'b1;
                                    emit     = 1'b1;
                                    emit_sym = r_cur.sym;
                                    n_cur    = r_root;
                                end
                            end else if (child_out) begin
                                o_pop = 1'b1;
                                n_cur = r_root;
                            end else begin
                                o_pop   = 1'b1;
                                rd_en   = 1'b1;
                                n_state = hftd_pkg::ST_READ;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            hftd_pkg::ST_READ: begin
                if (r_rd.leaf) begin
                    if (slot_free) begin
                        emit     = 1'b1;
                        emit_sym = r_rd.sym;
                        n_cur    = r_root;
                        n_state  = hftd_pkg::ST_IDLE;
                    end
                end else begin
                    n_cur   = r_rd;
                    n_state = hftd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hftd_pkg::ST_IDLE;
            end
        endcase
    end

    // symbol count, finish flag and output register
    always_comb begin
        n_left      = r_left;
        n_finished  = r_finished;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out.symbol = emit_sym;
            n_out.last   = (r_left == hftd_pkg::CNT_W'(1));
            if (r_left != '0) begin
                n_left = r_left - 1'b1;
            end
            if (r_left == hftd_pkg::CNT_W'(1)) begin
                n_finished = 1'b1;
            end
        end
        if (i_cfg_we) begin
            n_left     = i_cfg_data;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hftd_pkg::ST_IDLE;
            r_cur       <= '0;
            r_root      <= '0;
            r_left      <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_root      <= n_root;
            r_left      <= n_left;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // node memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[hftd_pkg::NODE_AW'(i_head.op.idx)] <= i_head.op.node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[hftd_pkg::NODE_AW'(next_child)];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### src/huffman_tree_bit_decoder_core.sv
// Top level of the Huffman tree bit decoder: front queue plus tree-walk back end.
// Timing: with the queue empty and the output free, a bit that steps to a leaf passes
//   the queue entry, the registered node read and the output register; a bit at a leaf root skips the read.
// A bit that steps to a child passes through ST_IDLE and ST_READ, set by the registered read of
//   the node memory; node writes, ignored bits and bits at a leaf root are handled in ST_IDLE alone.
// Reset (i_rst_n low, synchronous): queue empty, walk at the root, count 0, output idle.
module huffman_tree_bit_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hftd_pkg::t_in_item          i_data,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output hftd_pkg::t_out_item         o_data,
    // symbol count register
    input  logic                        i_cfg_we,
    input  logic [hftd_pkg::CNT_W-1:0]  i_cfg_data
);

    hftd_pkg::t_qhead head;
    logic             pop;

    // Front: takes a request whenever the two-entry queue has room, so a new
    // request lands while the back end walks the tree or waits on the output.
    hftd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back: holds the node memory, the current node entry and a copy of the
    // root entry. A bit steps through the child read; a leaf emits its symbol
    // into the output register and the walk returns to the root.
    hftd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

### src/hftd_checker.sv
// Port-level checker for the Huffman tree bit decoder, bound to the top level.
`include "assert_macros.svh"

module hftd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input hftd_pkg::t_out_item o_data
);

    // a stalled result holds its value
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))

    // reset empties the output register
    `CHK_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !o_valid)

    // reset empties the request queue, so it can take a request at once
    `CHK_ASSERT_ALWAYS(a_rst_queue_open, i_clk, !i_rst_n |=> o_ready)

endmodule

bind huffman_tree_bit_decoder_core hftd_checker u_hftd_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the Huffman tree bit decoder core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hftd_pkg::*;

    localparam int WORK_TARGET = 525;    // directed plus about 500 random requests
    localparam int HOLD_AT     = 150;    // request count that arms the long sink hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_AT    = 440;    // from here on neither side idles
    localparam int DRAIN_WAIT  = 8;      // cycles for in-flight requests that emit nothing
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_in_item         req;
        bit               typed;     // expected symbol written into the row
        t_out_item        res;
        logic [CNT_W-1:0] count;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    huffman_tree_bit_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted decoder state
    t_node            tree_mem [NODE_COUNT];
    bit               node_loaded [NODE_COUNT];
    logic [IDX_W-1:0] walk_node;
    logic [CNT_W-1:0] count_left;
    bit               count_done;

    t_out_item pending_symbols [$];
    t_stim_row stim_rows [$];

    int  fail_count   = 0;
    int  work_count   = 0;
    int  cycle_count  = 0;
    bit  hold_request = 1'b0;
    bit  hold_done    = 1'b0;
    bit  no_idle      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // One request through the tree walk; returns 1 when a symbol comes out.
    // Indexes and children are 10 bits wide, so they never point past the table.
    function automatic bit decode_step(input t_in_item req, output t_out_item res);
        t_node            entry;
        logic [IDX_W-1:0] next_idx;
        res = '0;
        if (req.cmd == CMD_NODE_WR) begin
            tree_mem[req.node_index] = {req.node_is_leaf, req.left_child,
                                        req.right_child, req.leaf_symbol};
            node_loaded[req.node_index] = 1'b1;
            walk_node = '0;
            return 1'b0;
        end
        if (count_done)
            return 1'b0;
        entry = tree_mem[walk_node];
        // a leaf root emits on every bit without stepping
        if (!entry.leaf) begin
            next_idx = req.code_bit ? entry.right : entry.left;
            entry = tree_mem[next_idx];
            if (!entry.leaf) begin
                walk_node = next_idx;
                return 1'b0;
            end
        end
        res.symbol = entry.sym;
        res.last   = 1'b0;
        if (count_left != '0) begin
            count_left = count_left - 1'b1;
            if (count_left == '0) begin
                res.last   = 1'b1;
                count_done = 1'b1;
            end
        end
        walk_node = '0;
        return 1'b1;
    endfunction

    // True when a bit of this value only touches table entries already loaded.
    function automatic bit bit_reads_loaded(input logic code_bit);
        t_node entry;
        if (!node_loaded[walk_node])
            return 1'b0;
        entry = tree_mem[walk_node];
        if (entry.leaf)
            return 1'b1;
        return node_loaded[code_bit ? entry.right : entry.left];
    endfunction

    function automatic t_in_item random_request();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic void row_node(input logic [IDX_W-1:0] idx, input logic leaf,
                                     input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                                     input logic signed [SYM_W-1:0] sym);
        t_stim_row r;
        r.kind  = ROW_REQ;
        r.req   = '0;
        r.req.cmd          = CMD_NODE_WR;
        r.req.node_index   = idx;
        r.req.node_is_leaf = leaf;
        r.req.left_child   = lc;
        r.req.right_child  = rc;
        r.req.leaf_symbol  = sym;
        r.typed = 1'b0;
        r.res   = '0;
        r.count = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_bit(input logic b, input bit typed,
                                    input logic signed [SYM_W-1:0] sym, input logic last);
        t_stim_row r;
        r.kind  = ROW_REQ;
        r.req   = '0;
        r.req.cmd      = CMD_BIT;
        r.req.code_bit = b;
        r.typed = typed;
        r.res   = {sym, last};
        r.count = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [CNT_W-1:0] value);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.req   = '0;
        r.typed = 1'b0;
        r.res   = '0;
        r.count = value;
        stim_rows.push_back(r);
    endfunction

    // Offer one request, hold it until accepted, then update the prediction.
    // Called right after a rising edge.
    task automatic issue_request(input t_in_item req, input bit typed,
                                 input t_out_item typed_res);
        t_out_item res;
        bit        produced;
        bit        ignored;
        ignored = (req.cmd == CMD_BIT) && count_done;
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        produced = decode_step(req, res);
        if (typed)
            pending_symbols.push_back(typed_res);
        else if (produced)
            pending_symbols.push_back(res);
        if (!ignored)
            work_count++;
        hold_request = (work_count >= HOLD_AT);
        no_idle      = (work_count >= QUIET_AT);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Symbol count is only written once the decoder has drained.
    task automatic load_symbol_count(input logic [CNT_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_left = value;
        count_done = 1'b0;
    endtask

    // Full binary tree on random table slots, children loaded before parents.
    task automatic build_random_tree();
        int unsigned slot [15];
        int unsigned m;
        int unsigned pick;
        bit          dup;
        t_in_item    req;
        m = ($urandom_range(0, 7) == 0) ? 1 : 2 * $urandom_range(1, 7) + 1;
        slot[0] = 0;
        for (int k = 1; k < m; k++) begin
            do begin
                pick = $urandom_range(0, NODE_COUNT - 1);
                dup  = 1'b0;
                for (int j = 0; j < k; j++)
                    if (slot[j] == pick) dup = 1'b1;
            end while (dup);
            slot[k] = pick;
        end
        for (int k = m - 1; k >= 0; k--) begin
            req = random_request();
            req.cmd        = CMD_NODE_WR;
            req.node_index = IDX_W'(slot[k]);
            if (2 * k + 2 < m) begin
                req.node_is_leaf = 1'b0;
                req.left_child   = IDX_W'(slot[2 * k + 1]);
                req.right_child  = IDX_W'(slot[2 * k + 2]);
                // now and then a branch loops back to the root or to itself
                case ($urandom_range(0, 11))
                    0:       req.right_child = IDX_W'(slot[0]);
                    1:       req.left_child  = IDX_W'(slot[k]);
                    default: ;
                endcase
            end else begin
                req.node_is_leaf = 1'b1;
            end
            issue_request(req, 1'b0, '0);
        end
    endtask

    // Code bits with random content, broken up by stray node writes.
    task automatic stream_bits();
        int unsigned n_bits;
        int unsigned idle_bits;
        t_in_item    req;
        n_bits    = $urandom_range(10, 60);
        idle_bits = 0;
        for (int k = 0; k < n_bits && idle_bits < 3; k++) begin
            req = random_request();
            if ($urandom_range(0, 15) == 0) begin
                req.cmd = CMD_NODE_WR;
            end else begin
                req.cmd = CMD_BIT;
                if (!bit_reads_loaded(req.code_bit))
                    req.code_bit = ~req.code_bit;
                if (!bit_reads_loaded(req.code_bit)) begin
                    // both children unloaded: load the wanted one as a leaf first
                    req.cmd          = CMD_NODE_WR;
                    req.node_index   = req.code_bit ? tree_mem[walk_node].right
                                                    : tree_mem[walk_node].left;
                    req.node_is_leaf = 1'b1;
                end
            end
            if (req.cmd == CMD_BIT && count_done)
                idle_bits++;
            issue_request(req, 1'b0, '0);
        end
    endtask

    // Result sink: random stall bursts plus a long hold-off that backs up the core;
    // the hold-off repeats until the input has been seen stalled during one
    initial begin : result_sink
        int unsigned stall_left;
        bit          holding;
        stall_left = 0;
        holding    = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                i_ready <= 1'b0;
                stall_left--;
                if (holding && i_valid && !o_ready)
                    hold_done = 1'b1;
            end else begin
                i_ready <= 1'b1;
                holding = 1'b0;
                if (hold_request && !hold_done && !no_idle) begin
                    stall_left = HOLD_CYCLES;
                    holding    = 1'b1;
                end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
        end
    end

    // Compare each accepted result with the oldest predicted symbol
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected result: symbol %0d last %0b", o_data.symbol, o_data.last);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (o_data.symbol !== want.symbol) begin
                    $error("symbol mismatch: expected %0d, actual %0d",
                           want.symbol, o_data.symbol);
                    fail_count++;
                end
                if (o_data.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, o_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [CNT_W-1:0] next_count;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        walk_node  = '0;
        count_left = '0;
        count_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tree: root -> (1023 leaf, 1 -> (2 leaf, 3 leaf)), extremes of index and symbol
        row_node(0,    1'b0, 1023, 1,    0);
        row_node(1023, 1'b1, 0,    0,    -32768);
        row_node(1,    1'b0, 2,    3,    0);
        row_node(2,    1'b1, 1023, 1023, 32767);
        row_node(3,    1'b1, 0,    0,    1);
        row_bit(1'b0, 1'b1, -32768, 1'b0);
        row_bit(1'b1, 1'b0, 0, 1'b0);
        row_bit(1'b0, 1'b1, 32767, 1'b0);
        row_bit(1'b1, 1'b0, 0, 1'b0);
        row_bit(1'b1, 1'b1, 1, 1'b0);
        row_bit(1'b1, 1'b0, 0, 1'b0);
        // node write mid-code: the walk restarts at the root
        row_node(3,    1'b1, 0,    0,    5);
        row_bit(1'b1, 1'b0, 0, 1'b0);
        row_bit(1'b1, 1'b1, 5, 1'b0);
        // leaf root: every bit emits the root symbol
        row_node(0,    1'b1, 0,    0,    -1);
        row_bit(1'b0, 1'b1, -1, 1'b0);
        row_bit(1'b1, 1'b1, -1, 1'b0);
        // count of two, then bits after the last symbol are dropped
        row_cfg(2);
        row_bit(1'b0, 1'b1, -1, 1'b0);
        row_bit(1'b1, 1'b1, -1, 1'b1);
        row_bit(1'b0, 1'b0, 0, 1'b0);
        // node writes still land after the last symbol
        row_node(0,    1'b0, 1023, 1,    0);
        row_cfg({CNT_W{1'b1}});
        row_bit(1'b0, 1'b1, -32768, 1'b0);
        row_cfg(1);
        row_bit(1'b1, 1'b0, 0, 1'b0);
        row_bit(1'b1, 1'b1, 5, 1'b1);
        row_bit(1'b0, 1'b0, 0, 1'b0);

        foreach (stim_rows[n]) begin
            if (stim_rows[n].kind == ROW_CFG)
                load_symbol_count(stim_rows[n].count);
            else
                issue_request(stim_rows[n].req, stim_rows[n].typed, stim_rows[n].res);
        end

        // Random trees and code streams under changing symbol counts
        while (work_count < WORK_TARGET) begin
            if (count_done || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       next_count = '0;
                    1:       next_count = {CNT_W{1'b1}};
                    2, 3:    next_count = CNT_W'($urandom_range(1, 12));
                    default: next_count = CNT_W'($urandom);
                endcase
                load_symbol_count(next_count);
            end
            build_random_tree();
            stream_bits();
        end

        i_valid <= 1'b0;
        no_idle = 1'b1;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
